// ----- rtl/core/jce_pkg.sv -----
// Shared types, constants and codes for the joystick command encoder.
// No dependencies; every other file in rtl/core imports this package.
package jce_pkg;

  // Queue between the classify stage and the record emitter
  localparam int unsigned JCE_QUEUE_DEPTH = 2;

  localparam int unsigned ADC_W      = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned NUM_PRESETS = 5;
  localparam int unsigned NUM_SLOTS   = 10;
  localparam int unsigned SLOT_W      = 4;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MAX        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARM_STEP_MAX     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_HYSTERESIS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ELBOW_HYSTERESIS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AXIS_PERIOD      = 3'd4;

  typedef enum logic [1:0] {
    CMD_PRESET = 2'd0,
    CMD_GRIP   = 2'd1,
    CMD_MOVE   = 2'd2,
    CMD_ARM    = 2'd3
  } cmd_e;

  localparam logic [2:0] DIR_STOP    = 3'd0;
  localparam logic [2:0] DIR_FORWARD = 3'd1;
  localparam logic [2:0] DIR_BACK    = 3'd2;
  localparam logic [2:0] DIR_RIGHT   = 3'd3;
  localparam logic [2:0] DIR_LEFT    = 3'd4;

  localparam logic [2:0] JOINT_BASE     = 3'd0;
  localparam logic [2:0] JOINT_SHOULDER = 3'd1;
  localparam logic [2:0] JOINT_ELBOW    = 3'd2;

  // Record slots of one scan, in emission order; presets take slots 0 to 4
  localparam logic [SLOT_W-1:0] SLOT_GRIP     = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_MOVE     = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_BASE     = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_SHOULDER = 4'd8;
  localparam logic [SLOT_W-1:0] SLOT_ELBOW    = 4'd9;

  localparam logic [7:0] BASE_MIN     = 8'd0;
  localparam logic [7:0] BASE_MAX     = 8'd180;
  localparam logic [7:0] SHOULDER_MIN = 8'd20;
  localparam logic [7:0] SHOULDER_MAX = 8'd160;
  localparam logic [7:0] ELBOW_OFFSET = 8'd10;
  localparam logic [7:0] ANGLE_HOME   = 8'd90;

  typedef struct packed {
    logic [31:0]      time_ms;
    logic             grip_pressed;
    logic [4:0]       preset_pressed;
    logic [ADC_W-1:0] left_x;
    logic [ADC_W-1:0] left_y;
    logic [ADC_W-1:0] right_x;
    logic [ADC_W-1:0] right_y;
    logic [ADC_W-1:0] elbow_pot;
  } in_t;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] target;
    logic [2:0] direction;
    logic [7:0] amount;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [7:0]  drive_max;
    logic [3:0]  arm_step_max;
    logic [7:0]  speed_hysteresis;
    logic [7:0]  elbow_hysteresis;
    logic [15:0] axis_period;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    drive_max:        8'd220,
    arm_step_max:     4'd3,
    speed_hysteresis: 8'd10,
    elbow_hysteresis: 8'd3,
    axis_period:      16'd50
  };

  // Scan after the axis arithmetic, before the state compare
  typedef struct packed {
    logic [31:0]       time_ms;
    logic              grip;
    logic [4:0]        presets;
    logic [2:0]        dir;
    logic [7:0]        spd;
    logic signed [4:0] base_step;
    logic signed [4:0] shoulder_step;
    logic [7:0]        elbow_angle;
  } axis_t;

  // One queued scan: which records to send and their amounts
  typedef struct packed {
    logic [NUM_SLOTS-1:0] mask;
    logic                 grip_closed;
    logic [2:0]           move_dir;
    logic [7:0]           move_spd;
    logic [7:0]           base_angle;
    logic [7:0]           shoulder_angle;
    logic [7:0]           elbow_angle;
  } entry_t;

endpackage

// ----- rtl/core/joystick_command_encoder_core.sv -----
// Joystick command encoder top level: configuration registers, axis pipeline,
// classify stage, scan queue and record emitter. Uses jce_pkg and all jce_* modules.
// Usage:
//   Scan channel (in_valid_i / in_ready_o / in_data_i) takes one controller scan.
//   Record channel (out_valid_o / out_ready_i / out_data_o) gives the command
//   records of each scan in order; the final one of a scan has last set. A scan
//   that changes nothing gives no record.
//   Configuration channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i)
//   is always ready; unknown indexes are ignored. Write it only while idle.
// Timing:
//   A scan passes three arithmetic stages, the classify stage and the queue; the
//   emitter then loads its first record into the output register. Scans are taken
//   every cycle while nothing downstream stalls; the emitter sends one record per
//   cycle while out_ready_i allows, so the record count of each scan sets the sustained rate.
// Reset:
//   Registers return to their defaults, the gripper opens, drive state reads
//   stop at speed 0, all joints sit at 90 and the throttle time is 0.
// Stalls:
//   When out_ready_i is low the output record holds, the queue fills, and then
//   the pipeline backs up to in_ready_o.
module joystick_command_encoder_core #(
  parameter int unsigned QueueDepth = jce_pkg::JCE_QUEUE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  jce_pkg::in_t                     in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output jce_pkg::out_t                    out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [jce_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [jce_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import jce_pkg::*;

  cfg_t   cfg_q, cfg_d;
  logic   axis_valid, axis_ready;
  axis_t  axis;
  logic   ent_valid, ent_ready;
  entry_t ent;
  logic   head_valid, head_pop;
  entry_t head;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DRIVE_MAX:        cfg_d.drive_max        = cfg_data_i[7:0];
        CFG_ARM_STEP_MAX:     cfg_d.arm_step_max     = cfg_data_i[3:0];
        CFG_SPEED_HYSTERESIS: cfg_d.speed_hysteresis = cfg_data_i[7:0];
        CFG_ELBOW_HYSTERESIS: cfg_d.elbow_hysteresis = cfg_data_i[7:0];
        CFG_AXIS_PERIOD:      cfg_d.axis_period      = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  jce_map u_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (axis_valid),
    .out_ready_i (axis_ready),
    .out_data_o  (axis)
  );

  jce_classify u_classify (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .axis_valid_i (axis_valid),
    .axis_ready_o (axis_ready),
    .axis_i       (axis),
    .ent_valid_o  (ent_valid),
    .ent_ready_i  (ent_ready),
    .ent_o        (ent)
  );

  jce_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (ent_valid),
    .push_ready_o (ent_ready),
    .push_data_i  (ent),
    .pop_valid_o  (head_valid),
    .pop_ready_i  (head_pop),
    .pop_data_o   (head)
  );

  jce_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (head_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ----- rtl/core/jce_map.sv -----
// Axis arithmetic pipeline: deadzone maps of the four stick axes and the elbow pot.
// Three register stages; constant divisions by reciprocal multiply. Uses jce_pkg.
module jce_map (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  jce_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  jce_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output jce_pkg::axis_t out_data_o
);
  import jce_pkg::*;

  localparam int unsigned NUM_W     = 9;
  localparam int unsigned PROD_W    = 17;
  localparam int unsigned RECIP_W   = 18;
  localparam int unsigned DIV_SHIFT = 26;
  localparam int unsigned POS_DIV   = 461;
  localparam int unsigned NEG_DIV   = 462;
  localparam int unsigned EPROD_W   = 18;
  localparam int unsigned ERECIP_W  = 19;
  localparam int unsigned E_SHIFT   = 28;
  localparam int unsigned ADC_FULL  = 1023;

  localparam logic [ADC_W-1:0] POS_START = 10'd562;
  localparam logic [ADC_W-1:0] NEG_END   = 10'd462;
  localparam logic [7:0]       ELBOW_SPAN = 8'd160;

  // Round-up reciprocals, exact for every numerator below 2^PROD_W or 2^EPROD_W
  localparam logic [RECIP_W-1:0] RECIP_POS =
    RECIP_W'(((64'd1 << DIV_SHIFT) + POS_DIV - 1) / POS_DIV);
  localparam logic [RECIP_W-1:0] RECIP_NEG =
    RECIP_W'(((64'd1 << DIV_SHIFT) + NEG_DIV - 1) / NEG_DIV);
  localparam logic [ERECIP_W-1:0] RECIP_ELBOW =
    ERECIP_W'(((64'd1 << E_SHIFT) + ADC_FULL - 1) / ADC_FULL);

  typedef enum logic [1:0] {
    ZONE_DEAD = 2'd0,
    ZONE_POS  = 2'd1,
    ZONE_NEG  = 2'd2
  } zone_e;

  typedef struct packed {
    logic [31:0]       time_ms;
    logic              grip;
    logic [4:0]        presets;
    zone_e [3:0]       zone;
    logic [3:0][PROD_W-1:0] prod;
    logic [EPROD_W-1:0] eprod;
  } s1_t;

  typedef struct packed {
    logic [31:0]       time_ms;
    logic              grip;
    logic [4:0]        presets;
    zone_e [3:0]       zone;
    logic [3:0][7:0]   quo;
    logic [7:0]        equo;
  } s2_t;

  function automatic zone_e zone_of(input logic [ADC_W-1:0] r);
    zone_e z;
    if (r >= POS_START) begin
      z = ZONE_POS;
    end else if (r <= NEG_END) begin
      z = ZONE_NEG;
    end else begin
      z = ZONE_DEAD;
    end
    return z;
  endfunction

  function automatic logic [NUM_W-1:0] numer(input logic [ADC_W-1:0] r);
    logic [ADC_W-1:0] n;
    if (r >= POS_START) begin
      n = r - POS_START;
    end else begin
      n = r;
    end
    return n[NUM_W-1:0];
  endfunction

  function automatic logic [7:0] div_const(input logic [PROD_W-1:0] x, input zone_e z);
    logic [PROD_W+RECIP_W-1:0] p;
    p = (PROD_W+RECIP_W)'(x) *
        (PROD_W+RECIP_W)'((z == ZONE_POS) ? RECIP_POS : RECIP_NEG);
    return p[DIV_SHIFT +: 8];
  endfunction

  function automatic logic [7:0] mag_of(input zone_e z, input logic [7:0] q,
                                        input logic [7:0] m);
    logic [7:0] mag;
    case (z)
      ZONE_POS: mag = q;
      ZONE_NEG: mag = m - q;
      default:  mag = '0;
    endcase
    return mag;
  endfunction

  function automatic logic signed [4:0] step_of(input zone_e z, input logic [7:0] q,
                                               input logic [7:0] m);
    logic [7:0] mag;
    logic signed [4:0] s;
    mag = mag_of(z, q, m);
    case (z)
      ZONE_POS: s = $signed({1'b0, mag[3:0]});
      ZONE_NEG: s = -$signed({1'b0, mag[3:0]});
      default:  s = '0;
    endcase
    return s;
  endfunction

  // Axis order in the stage arrays: 0 left_x, 1 left_y, 2 right_x, 3 right_y
  logic [7:0] arm_m;
  logic       v1_q, v2_q, v3_q;
  logic       rdy1, rdy2, rdy3;
  s1_t        s1_d, s1_q;
  s2_t        s2_d, s2_q;
  axis_t      s3_d, s3_q;
  logic [EPROD_W+ERECIP_W-1:0] eprod_full;
  logic [7:0] mag_f, mag_t;

  assign arm_m = {4'b0, cfg_i.arm_step_max};

  always_comb begin
    s1_d.time_ms = in_data_i.time_ms;
    s1_d.grip    = in_data_i.grip_pressed;
    s1_d.presets = in_data_i.preset_pressed;
    s1_d.zone[0] = zone_of(in_data_i.left_x);
    s1_d.zone[1] = zone_of(in_data_i.left_y);
    s1_d.zone[2] = zone_of(in_data_i.right_x);
    s1_d.zone[3] = zone_of(in_data_i.right_y);
    s1_d.prod[0] = PROD_W'(numer(in_data_i.left_x)) * PROD_W'(cfg_i.drive_max);
    s1_d.prod[1] = PROD_W'(numer(in_data_i.left_y)) * PROD_W'(cfg_i.drive_max);
    s1_d.prod[2] = PROD_W'(numer(in_data_i.right_x)) * PROD_W'(arm_m);
    s1_d.prod[3] = PROD_W'(numer(in_data_i.right_y)) * PROD_W'(arm_m);
    s1_d.eprod   = EPROD_W'(in_data_i.elbow_pot) * EPROD_W'(ELBOW_SPAN);
  end

  always_comb begin
    s2_d.time_ms = s1_q.time_ms;
    s2_d.grip    = s1_q.grip;
    s2_d.presets = s1_q.presets;
    s2_d.zone    = s1_q.zone;
    for (int i = 0; i < 4; i++) begin
      s2_d.quo[i] = div_const(s1_q.prod[i], s1_q.zone[i]);
    end
    eprod_full = (EPROD_W+ERECIP_W)'(s1_q.eprod) * (EPROD_W+ERECIP_W)'(RECIP_ELBOW);
    s2_d.equo  = eprod_full[E_SHIFT +: 8];
  end

  always_comb begin
    mag_f = mag_of(s2_q.zone[1], s2_q.quo[1], cfg_i.drive_max);
    mag_t = mag_of(s2_q.zone[0], s2_q.quo[0], cfg_i.drive_max);
    s3_d.time_ms = s2_q.time_ms;
    s3_d.grip    = s2_q.grip;
    s3_d.presets = s2_q.presets;
    if (mag_f > mag_t) begin
      s3_d.dir = (s2_q.zone[1] == ZONE_POS) ? DIR_FORWARD : DIR_BACK;
      s3_d.spd = mag_f;
    end else if (mag_t != 8'd0) begin
      s3_d.dir = (s2_q.zone[0] == ZONE_POS) ? DIR_RIGHT : DIR_LEFT;
      s3_d.spd = mag_t;
    end else begin
      s3_d.dir = DIR_STOP;
      s3_d.spd = '0;
    end
    s3_d.base_step     = step_of(s2_q.zone[2], s2_q.quo[2], arm_m);
    s3_d.shoulder_step = step_of(s2_q.zone[3], s2_q.quo[3], arm_m);
    s3_d.elbow_angle   = s2_q.equo + ELBOW_OFFSET;
  end

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) s1_q <= s1_d;
    if (rdy2 && v1_q)       s2_q <= s2_d;
    if (rdy3 && v2_q)       s3_q <= s3_d;
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = s3_q;

endmodule

// ----- rtl/core/jce_classify.sv -----
// Classify stage: compares one mapped scan against the sent state and decides its records.
// Holds the gripper, drive, joint and throttle state. Uses jce_pkg.
module jce_classify (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  jce_pkg::cfg_t   cfg_i,
  input  logic            axis_valid_i,
  output logic            axis_ready_o,
  input  jce_pkg::axis_t  axis_i,
  output logic            ent_valid_o,
  input  logic            ent_ready_i,
  output jce_pkg::entry_t ent_o
);
  import jce_pkg::*;

  logic        closed_q, closed_d;
  logic        grip_was_q;
  logic [2:0]  sent_dir_q;
  logic [7:0]  sent_spd_q;
  logic [7:0]  base_q, shoulder_q, elbow_q;
  logic [31:0] last_time_q;

  logic [31:0]       elapsed;
  logic              due, grip_edge, move_chg, base_chg, shoulder_chg, elbow_chg;
  logic [7:0]        spd_diff, elbow_diff;
  logic signed [9:0] base_sum, shoulder_sum;
  logic [7:0]        base_d, shoulder_d;
  logic              fire;

  assign elapsed   = axis_i.time_ms - last_time_q;
  assign due       = elapsed >= {16'd0, cfg_i.axis_period};
  assign grip_edge = axis_i.grip && !grip_was_q;
  assign closed_d  = closed_q ^ grip_edge;

  always_comb begin
    spd_diff = (axis_i.spd >= sent_spd_q) ? axis_i.spd - sent_spd_q
                                          : sent_spd_q - axis_i.spd;
    move_chg = (axis_i.dir != sent_dir_q) || (spd_diff > cfg_i.speed_hysteresis);

    base_sum = $signed({2'b00, base_q}) + {{5{axis_i.base_step[4]}}, axis_i.base_step};
    if (base_sum < $signed({2'b00, BASE_MIN})) begin
      base_d = BASE_MIN;
    end else if (base_sum > $signed({2'b00, BASE_MAX})) begin
      base_d = BASE_MAX;
    end else begin
      base_d = base_sum[7:0];
    end
    base_chg = base_d != base_q;

    shoulder_sum = $signed({2'b00, shoulder_q}) +
                   {{5{axis_i.shoulder_step[4]}}, axis_i.shoulder_step};
    if (shoulder_sum < $signed({2'b00, SHOULDER_MIN})) begin
      shoulder_d = SHOULDER_MIN;
    end else if (shoulder_sum > $signed({2'b00, SHOULDER_MAX})) begin
      shoulder_d = SHOULDER_MAX;
    end else begin
      shoulder_d = shoulder_sum[7:0];
    end
    shoulder_chg = shoulder_d != shoulder_q;

    elbow_diff = (axis_i.elbow_angle >= elbow_q) ? axis_i.elbow_angle - elbow_q
                                                 : elbow_q - axis_i.elbow_angle;
    elbow_chg  = elbow_diff > cfg_i.elbow_hysteresis;
  end

  always_comb begin
    ent_o.mask                = '0;
    ent_o.mask[NUM_PRESETS-1:0] = axis_i.presets;
    ent_o.mask[SLOT_GRIP]     = grip_edge;
    ent_o.mask[SLOT_MOVE]     = due && move_chg;
    ent_o.mask[SLOT_BASE]     = due && base_chg;
    ent_o.mask[SLOT_SHOULDER] = due && shoulder_chg;
    ent_o.mask[SLOT_ELBOW]    = due && elbow_chg;
    ent_o.grip_closed         = closed_d;
    ent_o.move_dir            = axis_i.dir;
    ent_o.move_spd            = axis_i.spd;
    ent_o.base_angle          = base_d;
    ent_o.shoulder_angle      = shoulder_d;
    ent_o.elbow_angle         = axis_i.elbow_angle;
  end

  // A scan with no records is dropped here; its state updates still apply
  assign axis_ready_o = ent_ready_i;
  assign fire         = axis_valid_i && ent_ready_i;
  assign ent_valid_o  = axis_valid_i && (ent_o.mask != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closed_q    <= 1'b0;
      grip_was_q  <= 1'b0;
      sent_dir_q  <= DIR_STOP;
      sent_spd_q  <= '0;
      base_q      <= ANGLE_HOME;
      shoulder_q  <= ANGLE_HOME;
      elbow_q     <= ANGLE_HOME;
      last_time_q <= '0;
    end else if (fire) begin
      closed_q   <= closed_d;
      grip_was_q <= axis_i.grip;
      if (due) begin
        last_time_q <= axis_i.time_ms;
        base_q      <= base_d;
        shoulder_q  <= shoulder_d;
        if (move_chg) begin
          sent_dir_q <= axis_i.dir;
          sent_spd_q <= axis_i.spd;
        end
        if (elbow_chg) elbow_q <= axis_i.elbow_angle;
      end
    end
  end

endmodule

// ----- rtl/core/jce_queue.sv -----
// Small FIFO of classified scans between the classify stage and the emitter.
// Flop storage, one read address. Uses jce_pkg for the entry type.
module jce_queue #(
  parameter int unsigned Depth = jce_pkg::JCE_QUEUE_DEPTH  // 2 to 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  jce_pkg::entry_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output jce_pkg::entry_t pop_data_o
);
  import jce_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = cnt_q != CntW'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + CntW'(push) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ----- rtl/core/jce_emit.sv -----
// Record emitter: walks the queued scan at the head, one record per cycle while the
// output is not stalled, into the output register. Uses jce_pkg.
module jce_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  jce_pkg::entry_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output jce_pkg::out_t   out_data_o
);
  import jce_pkg::*;

  logic [NUM_SLOTS-1:0] done_q, done_d, rem, pick;
  logic [SLOT_W-1:0]    sel;
  logic                 is_last, load;
  logic                 out_valid_q;
  out_t                 out_q, rec_d;

  always_comb begin
    rem = head_i.mask & ~done_q;
    sel = '0;
    // Lowest pending slot goes first
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (rem[i]) sel = SLOT_W'(i);
    end
    pick    = NUM_SLOTS'(1) << sel;
    is_last = (rem & ~pick) == '0;
  end

  always_comb begin
    rec_d.command   = CMD_PRESET;
    rec_d.target    = '0;
    rec_d.direction = DIR_STOP;
    rec_d.amount    = '0;
    rec_d.last      = is_last;
    if (sel < SLOT_GRIP) begin
      rec_d.target = sel[2:0];
    end else begin
      case (sel)
        SLOT_GRIP: begin
          rec_d.command = CMD_GRIP;
          rec_d.amount  = {7'd0, head_i.grip_closed};
        end
        SLOT_MOVE: begin
          rec_d.command   = CMD_MOVE;
          rec_d.direction = head_i.move_dir;
          rec_d.amount    = head_i.move_spd;
        end
        SLOT_BASE: begin
          rec_d.command = CMD_ARM;
          rec_d.target  = JOINT_BASE;
          rec_d.amount  = head_i.base_angle;
        end
        SLOT_SHOULDER: begin
          rec_d.command = CMD_ARM;
          rec_d.target  = JOINT_SHOULDER;
          rec_d.amount  = head_i.shoulder_angle;
        end
        SLOT_ELBOW: begin
          rec_d.command = CMD_ARM;
          rec_d.target  = JOINT_ELBOW;
          rec_d.amount  = head_i.elbow_angle;
        end
        default: begin
          rec_d.command = CMD_PRESET;
        end
      endcase
    end
  end

  assign load  = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && is_last;

  always_comb begin
    done_d = done_q;
    if (load) done_d = is_last ? '0 : (done_q | pick);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      done_q      <= '0;
    end else begin
      done_q <= done_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= rec_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- test/joystick_command_encoder_core_tb.sv -----
// Self-checking bench for joystick_command_encoder_core: directed scans, then
// random scans under several register settings and handshake idling patterns.
// Depends on jce_pkg and the RTL of the encoder; all records are predicted here.
module joystick_command_encoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jce_pkg::*;

  localparam int CLK_HALF        = 2;
  localparam int RESET_CYCLES    = 6;
  localparam int SETTLE_CYCLES   = 16;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 60;
  localparam int PRINT_CAP       = 100;
  localparam longint RUN_LIMIT_NS = 2_000_000;

  localparam int STICK_CENTER = 512;
  localparam int DEAD_BAND    = 50;
  localparam int ADC_FULL     = 1023;
  localparam int ELBOW_SPAN   = 160;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_t       in_data_i;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_t      out_data_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  joystick_command_encoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Encoder state as the bench sees it
  cfg_t       regs_q;
  logic       grip_closed_q;
  logic       grip_held_q;
  logic [2:0] move_dir_q;
  logic [7:0] move_spd_q;
  logic [7:0] joint_q [3];
  logic [31:0] axis_time_q;

  out_t scan_records [$];
  out_t records_due [$];
  int   mismatches = 0;

  int src_idle_pct  = 0;
  int sink_stall_pct = 0;

  // Directed table: glance_n < 0 means the row is checked against the predictor
  typedef struct {
    in_t scan;
    int  glance_n;
    int  glance_at;
  } plan_row_t;
  plan_row_t plan [$];
  out_t      glance [$];

  in_t         pose;
  int          pose_left = 0;
  logic [31:0] clock_ms;

  always @(posedge clk_i) out_ready_i <= ($urandom_range(0, 99) >= sink_stall_pct);

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < PRINT_CAP)
      $display("%0t ns: %s: got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : check_records
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (records_due.size() == 0) begin
        note_mismatch("record with none pending", 32'(out_data_o), '0);
      end else begin
        want = records_due.pop_front();
        if (out_data_o.command !== want.command)
          note_mismatch("command", 32'(out_data_o.command), 32'(want.command));
        if (out_data_o.target !== want.target)
          note_mismatch("target", 32'(out_data_o.target), 32'(want.target));
        if (out_data_o.direction !== want.direction)
          note_mismatch("direction", 32'(out_data_o.direction), 32'(want.direction));
        if (out_data_o.amount !== want.amount)
          note_mismatch("amount", 32'(out_data_o.amount), 32'(want.amount));
        if (out_data_o.last !== want.last)
          note_mismatch("last", 32'(out_data_o.last), 32'(want.last));
      end
    end
  end

  function automatic int magnitude(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int clamp_angle(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Deadzone map around the stick center, truncating division
  function automatic int stick_level(int reading, int full_scale);
    if (magnitude(reading - STICK_CENTER) < DEAD_BAND) return 0;
    if (reading > STICK_CENTER)
      return (reading - (STICK_CENTER + DEAD_BAND)) * full_scale
             / (ADC_FULL - STICK_CENTER - DEAD_BAND);
    return reading * full_scale / (STICK_CENTER - DEAD_BAND) - full_scale;
  endfunction

  function automatic out_t rec(cmd_e c, logic [2:0] t, logic [2:0] d, logic [7:0] a,
                               logic l);
    out_t r;
    r.command   = c;
    r.target    = t;
    r.direction = d;
    r.amount    = a;
    r.last      = l;
    return r;
  endfunction

  function automatic void add_record(cmd_e c, logic [2:0] t, logic [2:0] d, logic [7:0] a);
    scan_records.push_back(rec(c, t, d, a, 1'b0));
  endfunction

  // Work out the records of one accepted scan and advance the state
  function automatic void encode_scan(in_t s);
    logic [31:0] elapsed;
    logic [2:0]  dir;
    int          fwd, turn, spd, step, ang;
    out_t        tail;
    scan_records.delete();
    for (int i = 0; i < NUM_PRESETS; i++)
      if (s.preset_pressed[i]) add_record(CMD_PRESET, 3'(i), DIR_STOP, 8'd0);
    if (s.grip_pressed && !grip_held_q) begin
      grip_closed_q = !grip_closed_q;
      add_record(CMD_GRIP, '0, DIR_STOP, {7'd0, grip_closed_q});
    end
    grip_held_q = s.grip_pressed;
    elapsed = s.time_ms - axis_time_q;
    if (elapsed >= {16'd0, regs_q.axis_period}) begin
      axis_time_q = s.time_ms;
      fwd  = stick_level(int'(s.left_y), int'(regs_q.drive_max));
      turn = stick_level(int'(s.left_x), int'(regs_q.drive_max));
      dir  = DIR_STOP;
      spd  = 0;
      if (magnitude(fwd) > magnitude(turn)) begin
        dir = (fwd > 0) ? DIR_FORWARD : DIR_BACK;
        spd = magnitude(fwd);
      end else if (turn != 0) begin
        dir = (turn > 0) ? DIR_RIGHT : DIR_LEFT;
        spd = magnitude(turn);
      end
      if (dir != move_dir_q ||
          magnitude(spd - int'(move_spd_q)) > int'(regs_q.speed_hysteresis)) begin
        add_record(CMD_MOVE, '0, dir, 8'(spd));
        move_dir_q = dir;
        move_spd_q = 8'(spd);
      end
      step = stick_level(int'(s.right_x), int'(regs_q.arm_step_max));
      if (step != 0) begin
        ang = clamp_angle(int'(joint_q[JOINT_BASE[1:0]]) + step, int'(BASE_MIN),
                          int'(BASE_MAX));
        if (ang != int'(joint_q[JOINT_BASE[1:0]])) begin
          add_record(CMD_ARM, JOINT_BASE, DIR_STOP, 8'(ang));
          joint_q[JOINT_BASE[1:0]] = 8'(ang);
        end
      end
      step = stick_level(int'(s.right_y), int'(regs_q.arm_step_max));
      if (step != 0) begin
        ang = clamp_angle(int'(joint_q[JOINT_SHOULDER[1:0]]) + step, int'(SHOULDER_MIN),
                          int'(SHOULDER_MAX));
        if (ang != int'(joint_q[JOINT_SHOULDER[1:0]])) begin
          add_record(CMD_ARM, JOINT_SHOULDER, DIR_STOP, 8'(ang));
          joint_q[JOINT_SHOULDER[1:0]] = 8'(ang);
        end
      end
      ang = int'(s.elbow_pot) * ELBOW_SPAN / ADC_FULL + int'(ELBOW_OFFSET);
      if (magnitude(ang - int'(joint_q[JOINT_ELBOW[1:0]])) >
          int'(regs_q.elbow_hysteresis)) begin
        add_record(CMD_ARM, JOINT_ELBOW, DIR_STOP, 8'(ang));
        joint_q[JOINT_ELBOW[1:0]] = 8'(ang);
      end
    end
    if (scan_records.size() > 0) begin
      tail = scan_records.pop_back();
      tail.last = 1'b1;
      scan_records.push_back(tail);
    end
  endfunction

  function automatic in_t scan_of(logic [31:0] t, logic g, logic [4:0] p,
                                  logic [9:0] lx, logic [9:0] ly, logic [9:0] rx,
                                  logic [9:0] ry, logic [9:0] pot);
    in_t s;
    s.time_ms        = t;
    s.grip_pressed   = g;
    s.preset_pressed = p;
    s.left_x         = lx;
    s.left_y         = ly;
    s.right_x        = rx;
    s.right_y        = ry;
    s.elbow_pot      = pot;
    return s;
  endfunction

  function automatic void plan_scan(in_t s);
    plan.push_back('{s, -1, 0});
  endfunction

  function automatic void plan_glance(in_t s, int n);
    plan.push_back('{s, n, glance.size()});
  endfunction

  function automatic logic [9:0] pick_adc();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 10'(STICK_CENTER - DEAD_BAND + 1 + $urandom_range(0, 2 * DEAD_BAND - 2));
      3: begin
        case ($urandom_range(0, 3))
          0: return 10'(STICK_CENTER - DEAD_BAND - 1);
          1: return 10'(STICK_CENTER - DEAD_BAND);
          2: return 10'(STICK_CENTER + DEAD_BAND);
          default: return 10'(STICK_CENTER + DEAD_BAND + 1);
        endcase
      end
      default: return 10'($urandom);
    endcase
  endfunction

  // Hold a stick pose over a short run of scans so joints walk into their clamps
  function automatic in_t next_scan();
    in_t         s;
    int unsigned span;
    span = 32'(regs_q.axis_period);
    if (pose_left == 0) begin
      pose.left_x    = pick_adc();
      pose.left_y    = pick_adc();
      pose.right_x   = pick_adc();
      pose.right_y   = pick_adc();
      pose.elbow_pot = pick_adc();
      pose_left      = $urandom_range(1, 6);
    end
    pose_left--;
    case ($urandom_range(0, 9))
      0: ;
      1: clock_ms += $urandom;
      2: clock_ms += span - 1;
      3: clock_ms += span;
      default: clock_ms += $urandom_range(0, 2 * span + 1);
    endcase
    s                = pose;
    s.time_ms        = clock_ms;
    s.grip_pressed   = 1'($urandom);
    s.preset_pressed = ($urandom_range(0, 3) == 0) ? 5'($urandom) : '0;
    return s;
  endfunction

  task automatic send_scan(in_t s, int glance_n, int glance_at);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    do @(posedge clk_i); while (!in_ready_o);
    encode_scan(s);
    if (glance_n < 0) begin
      foreach (scan_records[k]) records_due.push_back(scan_records[k]);
    end else begin
      for (int k = 0; k < glance_n; k++) records_due.push_back(glance[glance_at + k]);
    end
  endtask

  task automatic run_plan();
    foreach (plan[i]) send_scan(plan[i].scan, plan[i].glance_n, plan[i].glance_at);
    plan.delete();
    glance.delete();
  endtask

  // Drop valid and hold until every pending record has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (records_due.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_DRIVE_MAX:        regs_q.drive_max        = data[7:0];
      CFG_ARM_STEP_MAX:     regs_q.arm_step_max     = data[3:0];
      CFG_SPEED_HYSTERESIS: regs_q.speed_hysteresis = data[7:0];
      CFG_ELBOW_HYSTERESIS: regs_q.elbow_hysteresis = data[7:0];
      CFG_AXIS_PERIOD:      regs_q.axis_period      = data[15:0];
      default: ;
    endcase
  endtask

  // Random junk above the register width checks the masking
  function automatic logic [CFG_DATA_W-1:0] cfg_word(int width, int val);
    logic [CFG_DATA_W-1:0] mask;
    mask = (width >= CFG_DATA_W) ? '1 : CFG_DATA_W'((1 << width) - 1);
    return (CFG_DATA_W'($urandom) & ~mask) | (CFG_DATA_W'(val) & mask);
  endfunction

  task automatic apply_settings(int drive, int step, int shyst, int ehyst, int interval);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(CFG_DRIVE_MAX, cfg_word(8, drive));
    write_reg(CFG_AXIS_PERIOD + 3'($urandom_range(1, 3)), CFG_DATA_W'($urandom));
    write_reg(CFG_ARM_STEP_MAX, cfg_word(4, step));
    write_reg(CFG_SPEED_HYSTERESIS, cfg_word(8, shyst));
    write_reg(CFG_ELBOW_HYSTERESIS, cfg_word(8, ehyst));
    write_reg(CFG_AXIS_PERIOD, cfg_word(16, interval));
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_DRIVE_MAX;
    cfg_data_i  = '0;

    regs_q        = CFG_RESET;
    grip_closed_q = 1'b0;
    grip_held_q   = 1'b0;
    move_dir_q    = DIR_STOP;
    move_spd_q    = '0;
    joint_q       = '{ANGLE_HOME, ANGLE_HOME, ANGLE_HOME};
    axis_time_q   = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    @(posedge clk_i);

    // Reset settings: throttle, buttons, every direction, first base and shoulder steps
    plan_glance(scan_of(32'd0, 1'b0, '0, '1, '1, '1, '1, '1), 0);
    plan_glance(scan_of(32'd10, 1'b1, 5'h1f, 10'd512, 10'd512, 10'd512, 10'd512, 10'd0), 6);
    glance.push_back(rec(CMD_PRESET, 3'd0, DIR_STOP, 8'd0, 1'b0));
    glance.push_back(rec(CMD_PRESET, 3'd1, DIR_STOP, 8'd0, 1'b0));
    glance.push_back(rec(CMD_PRESET, 3'd2, DIR_STOP, 8'd0, 1'b0));
    glance.push_back(rec(CMD_PRESET, 3'd3, DIR_STOP, 8'd0, 1'b0));
    glance.push_back(rec(CMD_PRESET, 3'd4, DIR_STOP, 8'd0, 1'b0));
    glance.push_back(rec(CMD_GRIP, '0, DIR_STOP, 8'd1, 1'b1));
    plan_glance(scan_of(32'd20, 1'b1, '0, 10'd512, 10'd512, 10'd512, 10'd512, 10'd0), 0);
    plan_glance(scan_of(32'd30, 1'b0, '0, 10'd512, 10'd512, 10'd512, 10'd512, 10'd0), 0);
    plan_glance(scan_of(32'd50, 1'b0, '0, 10'd512, '1, 10'd512, 10'd512, 10'd0), 2);
    glance.push_back(rec(CMD_MOVE, '0, DIR_FORWARD, 8'd220, 1'b0));
    glance.push_back(rec(CMD_ARM, JOINT_ELBOW, DIR_STOP, 8'd10, 1'b1));
    // One millisecond short of the interval: axes are skipped
    plan_glance(scan_of(32'd99, 1'b0, '0, 10'd512, '0, 10'd512, 10'd512, 10'd0), 0);
    plan_glance(scan_of(32'd100, 1'b0, '0, 10'd512, '0, 10'd512, 10'd512, 10'd0), 1);
    glance.push_back(rec(CMD_MOVE, '0, DIR_BACK, 8'd220, 1'b1));
    plan_glance(scan_of(32'd150, 1'b0, '0, '1, 10'd512, 10'd512, 10'd512, '1), 2);
    glance.push_back(rec(CMD_MOVE, '0, DIR_RIGHT, 8'd220, 1'b0));
    glance.push_back(rec(CMD_ARM, JOINT_ELBOW, DIR_STOP, 8'd170, 1'b1));
    plan_glance(scan_of(32'd200, 1'b0, '0, '0, 10'd512, 10'd512, 10'd512, '1), 1);
    glance.push_back(rec(CMD_MOVE, '0, DIR_LEFT, 8'd220, 1'b1));
    plan_glance(scan_of(32'd250, 1'b0, '0, 10'd512, 10'd512, 10'd512, 10'd512, '1), 1);
    glance.push_back(rec(CMD_MOVE, '0, DIR_STOP, 8'd0, 1'b1));
    plan_glance(scan_of(32'd300, 1'b0, '0, 10'd512, 10'd512, '1, '0, '1), 2);
    glance.push_back(rec(CMD_ARM, JOINT_BASE, DIR_STOP, 8'd93, 1'b0));
    glance.push_back(rec(CMD_ARM, JOINT_SHOULDER, DIR_STOP, 8'd87, 1'b1));
    run_plan();

    // Zero interval, full steps, no hysteresis: walk into the clamps across the time wrap
    apply_settings(255, 15, 0, 0, 0);
    for (int k = 0; k < 7; k++)
      plan_scan(scan_of(32'hffff_fff8 + 32'(k), 1'b0, '0, 10'd512, 10'd512, '1, '0, '1));
    plan_scan(scan_of(32'hffff_ffff, 1'b0, '0, 10'd512, 10'd461, 10'd512, 10'd512, '1));
    plan_scan(scan_of(32'd0, 1'b0, '0, 10'd512, 10'd562, 10'd512, 10'd512, '1));
    plan_scan(scan_of(32'd1, 1'b0, '0, 10'd563, 10'd463, 10'd512, 10'd512, '1));
    plan_scan(scan_of(32'd2, 1'b0, '0, 10'd512, 10'd512, 10'd512, 10'd512, 10'd1022));
    run_plan();

    // Zero full scales: sticks at the ends move nothing
    apply_settings(0, 0, 10, 3, 1);
    plan_scan(scan_of(32'd100, 1'b0, '0, '1, '0, '1, '0, '1));
    plan_scan(scan_of(32'd200, 1'b0, '0, '0, '1, '0, '1, '1));
    run_plan();

    clock_ms = 32'd200;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_settings(int'(CFG_RESET.drive_max), int'(CFG_RESET.arm_step_max),
                          int'(CFG_RESET.speed_hysteresis), int'(CFG_RESET.elbow_hysteresis),
                          int'(CFG_RESET.axis_period));
        1: apply_settings(255, 15, 0, 0, 0);
        2: apply_settings(1, 1, 255, 180, 65535);
        3: apply_settings(0, 0, $urandom_range(0, 255), $urandom_range(0, 180),
                          $urandom_range(1, 100));
        default: apply_settings($urandom_range(1, 255), $urandom_range(1, 15),
                                $urandom_range(0, 40), $urandom_range(0, 20),
                                $urandom_range(1, 120));
      endcase
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 45; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 45; end
        default: begin src_idle_pct = 38; sink_stall_pct = 38; end
      endcase
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ((p == 1 && k == 5) || $urandom_range(0, 39) == 0) drain();
        send_scan(next_scan(), -1, 0);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
